// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the byte dump formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition is followed by a consequence in the next clock cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bfmt_pkg.sv -----
// Package with the types, constants and helper functions of the byte dump formatter.
package bfmt_pkg;

    localparam int DEF_BYTES_PER_LINE = 16;
    localparam int DEF_OFFSET_DIGITS  = 6;
    localparam int COUNT_W            = 24;
    localparam int DIG_IDX_W          = 3;
    localparam int CMD_DEPTH          = 4;
    localparam int CMD_PTR_W          = $clog2(CMD_DEPTH);

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_A_LOW   = 8'h61;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic               is_end;
        logic               lead_nl;
        logic               need_offset;
        logic               nl_after;
        logic               hex_mode;
        logic [7:0]         data_byte;
        logic [COUNT_W-1:0] offset;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEAD_NL,
        S_OFFSET,
        S_SEP,
        S_SPACE,
        S_DIG,
        S_TRAIL_NL
    } bfmt_state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = CH_0 + {4'b0000, nib};
        end
        else
        begin
            ch = CH_A_LOW + {4'b0000, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// ----- hw/rtl/bfmt_front.sv -----
// Front end: accepts input items, tracks the byte count and line position, builds commands.
`include "assert_macros.svh"

module bfmt_front
    import bfmt_pkg::*;
#(
    parameter int BYTES_PER_LINE = DEF_BYTES_PER_LINE
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t din,
    input  logic     cfg_we,
    input  logic     cfg_data,
    output logic     cmd_push,
    output cmd_t     cmd,
    input  logic     cmd_full
);

    localparam int POS_W = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;

    logic [COUNT_W-1:0] count_reg, count_next, count_inc;
    logic [POS_W-1:0]   pos_reg, pos_next, pos_inc;
    logic               hex_mode_reg, hex_mode_next;
    logic               accept;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    always_comb
    begin
        count_inc = count_reg + COUNT_W'(1);
        if ((pos_reg == POS_W'(BYTES_PER_LINE - 1)) || (count_inc == '0))
        begin
            pos_inc = '0;
        end
        else
        begin
            pos_inc = pos_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        cmd.is_end      = (din.req_type == REQ_END);
        cmd.lead_nl     = (pos_reg != '0);
        cmd.need_offset = (pos_reg == '0);
        cmd.nl_after    = (pos_inc == '0);
        cmd.hex_mode    = hex_mode_reg;
        cmd.data_byte   = din.data_byte;
        cmd.offset      = count_reg;
    end

    assign cmd_push = accept;

    always_comb
    begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        hex_mode_next = hex_mode_reg;
        if (cfg_we)
        begin
            hex_mode_next = cfg_data;
        end
        if (accept)
        begin
            if (din.req_type == REQ_END)
            begin
                count_next = '0;
                pos_next   = '0;
            end
            else
            begin
                count_next = count_inc;
                pos_next   = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            pos_reg      <= '0;
            hex_mode_reg <= 1'b1;
        end
        else
        begin
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            hex_mode_reg <= hex_mode_next;
        end
    end

    `ASSERT_ALWAYS(a_pos_in_range, pos_reg <= POS_W'(BYTES_PER_LINE - 1), "line position out of range")
    `ASSERT_NEXT(a_end_clears, accept && (din.req_type == REQ_END), (count_reg == '0) && (pos_reg == '0), "end of input did not clear the count")

endmodule

// ----- hw/rtl/bfmt_cmd_fifo.sv -----
// Short command queue between the front end and the character sequencer.
`include "assert_macros.svh"

module bfmt_cmd_fifo
    import bfmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic valid
);

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_PTR_W:0]   count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full   = (count_reg == (CMD_PTR_W + 1)'(CMD_DEPTH));
    assign valid  = (count_reg != '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && valid;
    assign rd_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + CMD_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + CMD_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (CMD_PTR_W + 1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (CMD_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= (CMD_PTR_W + 1)'(CMD_DEPTH), "command queue overfilled")

endmodule

// ----- hw/rtl/bfmt_back.sv -----
// Back end: steps through each command and produces one dump character per cycle while the output is empty or popped.
`include "assert_macros.svh"

module bfmt_back
    import bfmt_pkg::*;
#(
    parameter int OFFSET_DIGITS = DEF_OFFSET_DIGITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd_in,
    output logic      cmd_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t dout
);

    bfmt_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [DIG_IDX_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;
    logic                 emit_ok, emit;
    logic [7:0]           ch;
    logic                 ch_last;
    logic [31:0]          offset_ext;
    logic [3:0]           nib;
    logic [2:0]           oct;

    function automatic bfmt_state_t first_state(input cmd_t c);
        bfmt_state_t s;
        if (c.is_end)
        begin
            s = c.lead_nl ? S_LEAD_NL : S_OFFSET;
        end
        else
        begin
            s = c.need_offset ? S_OFFSET : S_SPACE;
        end
        return s;
    endfunction

    assign emit_ok = !out_valid_reg || pop;

    always_comb
    begin
        offset_ext = {{(32 - COUNT_W){1'b0}}, cmd_reg.offset};
        nib        = offset_ext[idx_reg * 4 +: 4];
        case (idx_reg)
            3'd2:    oct = {1'b0, cmd_reg.data_byte[7:6]};
            3'd1:    oct = cmd_reg.data_byte[5:3];
            default: oct = cmd_reg.data_byte[2:0];
        endcase
        ch      = CH_SPACE;
        ch_last = 1'b0;
        case (state_reg)
            S_LEAD_NL:  ch = CH_NEWLINE;
            S_OFFSET:   ch = hex_char(nib);
            S_SEP:      ch = CH_SPACE;
            S_SPACE:    ch = CH_SPACE;
            S_DIG:
            begin
                if (cmd_reg.hex_mode)
                begin
                    ch = (idx_reg == '0) ? hex_char(cmd_reg.data_byte[3:0])
                                         : hex_char(cmd_reg.data_byte[7:4]);
                end
                else
                begin
                    ch = CH_0 | {5'b00000, oct};
                end
                ch_last = (idx_reg == '0) && !cmd_reg.nl_after;
            end
            S_TRAIL_NL:
            begin
                ch      = CH_NEWLINE;
                ch_last = 1'b1;
            end
            default:    ch = CH_SPACE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        cmd_pop    = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_in;
                    idx_next   = DIG_IDX_W'(OFFSET_DIGITS - 1);
                    state_next = first_state(cmd_in);
                end
            end
            default:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    if (ch_last)
                    begin
                        if (cmd_valid)
                        begin
                            cmd_pop    = 1'b1;
                            cmd_next   = cmd_in;
                            idx_next   = DIG_IDX_W'(OFFSET_DIGITS - 1);
                            state_next = first_state(cmd_in);
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        case (state_reg)
                            S_LEAD_NL:
                            begin
                                state_next = S_OFFSET;
                            end
                            S_OFFSET:
                            begin
                                if (idx_reg == '0)
                                begin
                                    state_next = cmd_reg.is_end ? S_TRAIL_NL : S_SEP;
                                end
                                else
                                begin
                                    idx_next = idx_reg - DIG_IDX_W'(1);
                                end
                            end
                            S_SEP:
                            begin
                                state_next = S_SPACE;
                            end
                            S_SPACE:
                            begin
                                state_next = S_DIG;
                                idx_next   = cmd_reg.hex_mode ? DIG_IDX_W'(1) : DIG_IDX_W'(2);
                            end
                            S_DIG:
                            begin
                                if (idx_reg == '0)
                                begin
                                    state_next = S_TRAIL_NL;
                                end
                                else
                                begin
                                    idx_next = idx_reg - DIG_IDX_W'(1);
                                end
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next       = 1'b1;
            out_next.out_char    = ch;
            out_next.last_of_run = ch_last;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign empty = !out_valid_reg;
    assign dout  = out_reg;

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEXT(a_idle_pickup, (state_reg == S_IDLE) && cmd_valid, state_reg != S_IDLE, "pending command not picked up")

endmodule

// ----- hw/rtl/byte_dump_formatter.sv -----
// Byte dump formatter: turns a byte stream into hex or octal dump text.
// Input side is a queue: an item (req_type, data_byte) transfers when push is
// high and full is low. A data byte yields a space and two hex or three octal
// digits, led by the six-digit hex offset and a space at the start of each line
// and followed by a newline when it completes a line. An end-of-input item
// closes a partial line, prints the final count and a newline, and clears it.
// Result side is a queue: the oldest character is on dout while empty is low
// and transfers when pop is high; last_of_run marks the final character of an
// input item. The cfg port writes the hex_mode register (1 hex, 0 octal).
// The character sequencer emits one character per cycle while dout is popped or
// empty, about 3.5 characters per byte in hex and 4.5 in octal on full lines.
// With the queues empty, the first character of an item passes the command queue,
// the sequencer's command register and the output register. A four-entry command
// queue lets input run ahead while the receiver stalls; full rises once it fills.
// Reset clears the byte count, sets hex mode and empties both queues.
module byte_dump_formatter
    import bfmt_pkg::*;
#(
    parameter int BYTES_PER_LINE = DEF_BYTES_PER_LINE,
    parameter int OFFSET_DIGITS  = DEF_OFFSET_DIGITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  din,
    output logic      empty,
    input  logic      pop,
    output out_item_t dout,
    input  logic      cfg_we,
    input  logic      cfg_data
);

    logic cmd_push, cmd_full, cmd_valid, cmd_pop;
    cmd_t cmd_wr, cmd_rd;

    bfmt_front #(
        .BYTES_PER_LINE(BYTES_PER_LINE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .din      (din),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd_push (cmd_push),
        .cmd      (cmd_wr),
        .cmd_full (cmd_full)
    );

    bfmt_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (cmd_wr),
        .full   (cmd_full),
        .rd_en  (cmd_pop),
        .rd_cmd (cmd_rd),
        .valid  (cmd_valid)
    );

    bfmt_back #(
        .OFFSET_DIGITS(OFFSET_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_in    (cmd_rd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .dout      (dout)
    );

endmodule
